FILE: hw/rtl/tap_tempo_estimator_top_assert.svh
// Assertion macros for the tap tempo estimator.
// Used by the top level only; expects clk and rst_n in the including scope.
`ifndef TAP_TEMPO_ESTIMATOR_TOP_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define TTE_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger
`define TTE_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/tte_pkg.sv
// Shared types, constants and helpers for the tap tempo estimator.
// No dependencies; imported by every module of the block but tte_ram.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  localparam int TAP_SLOTS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int STAMP_W    = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int TEMPO_W    = 14;
  localparam int HELD_W     = 4;
  localparam int NUM_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Sixteenths of a BPM per interval of one millisecond
  localparam logic [NUM_W-1:0]     Q4_PER_MINUTE_MS = 24'd960000;
  localparam logic [TEMPO_W-1:0]   TEMPO_SAT        = 14'h3FFF;
  localparam logic [HELD_W-1:0]    HELD_SAT         = 4'hF;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd2000;
  localparam logic [TEMPO_W-1:0]   TEMPO_MIN_RST = 14'd320;
  localparam logic [TEMPO_W-1:0]   TEMPO_MAX_RST = 14'd4800;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_MAX = 2'd2;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp_ms;
    logic               hold;
  } in_t;

  typedef struct packed {
    logic               tempo_valid;
    logic [TEMPO_W-1:0] tempo_q4;
    logic [HELD_W-1:0]  taps_held;
  } out_t;

  typedef enum logic {
    JOB_PASS,
    JOB_DIV
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [HELD_W-1:0]  held;
    logic [NUM_W-1:0]   num;
    logic [STAMP_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef enum logic {
    F_IDLE,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FIN
  } back_state_t;

  // Clamp a tap count to the width of the result field
  function automatic logic [HELD_W-1:0] held_field(input logic [31:0] n);
    logic [HELD_W-1:0] r;
    r = (n > 32'(HELD_SAT)) ? HELD_SAT : n[HELD_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tap_tempo_estimator_top.sv
// Tap tempo estimator: averages recent tap intervals into a tempo.
// Top level; depends on tte_pkg, tte_front, tte_queue, tte_back and the assertion header.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one tap: a wrapping
//   millisecond stamp and a hold flag. Result channel (out_valid / out_stall /
//   out_data) gives exactly one item per tap: tempo_valid, tempo_q4 in 1/16 BPM
//   and the number of stamps held. Configuration is a plain write port
//   (cfg_we, cfg_index, cfg_wdata) for timeout, tempo minimum and maximum.
//   A tap that yields no division (hold, first tap) goes from the front end
//   through the queue to the output register; a tempo tap first passes the
//   24-step serial divider. The front end takes no tap while it pushes a job
//   or the job queue is full, and the back end takes no job while it divides.
//   Reset: history empty, registers back to 2000 ms, 320 and 4800; the stamp
//   ring needs no clearing pass, so the block is ready in the first cycle.
//   Receiver stall: the output register holds its item, the back end keeps a
//   finished quotient, the queue fills and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module tap_tempo_estimator_top #(
  parameter int TAP_SLOTS   = tte_pkg::TAP_SLOTS_DEF,
  parameter int QUEUE_DEPTH = tte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire tte_pkg::in_t                   in_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      tte_pkg::out_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import tte_pkg::*;

  `include "tap_tempo_estimator_top_assert.svh"

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TEMPO_W-1:0]   tempo_min_r;
  logic [TEMPO_W-1:0]   tempo_max_r;

  q_wr_t q_wr;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  job_t  q_data;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      tempo_min_r <= TEMPO_MIN_RST;
      tempo_max_r <= TEMPO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_TEMPO_MIN: tempo_min_r <= cfg_wdata[TEMPO_W-1:0];
        CFG_TEMPO_MAX: tempo_max_r <= cfg_wdata[TEMPO_W-1:0];
        default: ;
      endcase
    end
  end

  tte_front #(
    .TAP_SLOTS (TAP_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .timeout_ms (timeout_r),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  tte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  tte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .tempo_min (tempo_min_r),
    .tempo_max (tempo_max_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A push always finds room: space was checked when the tap was taken
  `TTE_ASSERT_NOW(a_queue_no_overflow, q_wr.push, !q_full, "job pushed into a full queue")
  // The back end never pops an empty queue
  `TTE_ASSERT_NOW(a_queue_no_underflow, q_pop, !q_empty, "job popped from an empty queue")
  // The front end is busy for the cycle after it takes a tap
  `TTE_ASSERT_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "tap taken back to back")
  // The reported count never exceeds the ring size
  `TTE_ASSERT_NOW(a_held_bound, out_valid, 32'(out_data.taps_held) <= TAP_SLOTS, "count exceeds ring")

endmodule

`default_nettype wire

FILE: hw/rtl/tte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tte_queue.sv
// Short job queue between the tap front end and the divider back end.
// Depends on tte_pkg for the job types.
`timescale 1ns / 1ps
`default_nettype none

module tte_queue #(
  parameter int DEPTH = tte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tte_pkg::q_wr_t wr,
  output      logic          full,
  input  wire logic          pop,
  output      logic          empty,
  output      tte_pkg::job_t rd_data
);

  import tte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.job;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tte_front.sv
// Tap front end: accepts taps, keeps the stamp history and builds division and pass jobs.
// Depends on tte_pkg and tte_ram.
`timescale 1ns / 1ps
`default_nettype none

module tte_front #(
  parameter int TAP_SLOTS = tte_pkg::TAP_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire tte_pkg::in_t                    in_data,
  input  wire logic [tte_pkg::TIMEOUT_W-1:0]   timeout_ms,
  input  wire logic                            q_full,
  output      tte_pkg::q_wr_t                  q_wr
);

  import tte_pkg::*;

  localparam int SLOT_W = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TAP_SLOTS + 1);
  localparam int OFS_W  = CNT_W + 1;
  localparam int PROD_W = NUM_W + CNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TAP_SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TAP_SLOTS);
  localparam logic [CNT_W-1:0]  TWO_CNT   = CNT_W'(2);
  localparam logic [OFS_W-1:0]  SLOTS_OFS = OFS_W'(TAP_SLOTS);

  front_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0]   write_slot_r;
  logic [CNT_W-1:0]    tap_total_r;
  logic [STAMP_W-1:0]  last_stamp_r;
  logic [STAMP_W-1:0]  newest_r;
  job_kind_t           kind_r;
  logic [HELD_W-1:0]   held_r;
  logic [NUM_W-1:0]    num_r;

  logic                accept;
  logic                store;
  logic [STAMP_W-1:0]  gap;
  logic                restart;
  logic [SLOT_W-1:0]   slot_new, slot_next, oldest_slot;
  logic [CNT_W-1:0]    tot_base, tot_new, intervals;
  logic [OFS_W-1:0]    slot_ofs, back_ofs, oldest_ofs;
  logic [PROD_W-1:0]   prod;
  logic [STAMP_W-1:0]  oldest_stamp;
  logic [STAMP_W-1:0]  span;

  assign in_stall = (state_r != F_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;
  assign store    = accept && !in_data.hold;

  // Classify the tap against the history
  assign gap      = in_data.stamp_ms - last_stamp_r;
  assign restart  = (tap_total_r != '0) && (gap > STAMP_W'(timeout_ms));
  assign slot_new = restart ? '0 : write_slot_r;
  assign tot_base = restart ? '0 : tap_total_r;
  assign tot_new  = (tot_base < FULL_CNT) ? tot_base + 1'b1 : tot_base;
  assign slot_next = (slot_new == LAST_SLOT) ? '0 : slot_new + 1'b1;
  assign intervals = tot_new - 1'b1;

  // Locate the oldest stamp still held, counting back around the ring
  assign slot_ofs   = OFS_W'(slot_new);
  assign back_ofs   = OFS_W'(intervals);
  assign oldest_ofs = (slot_ofs >= back_ofs) ? slot_ofs - back_ofs
                                             : slot_ofs + SLOTS_OFS - back_ofs;
  assign oldest_slot = oldest_ofs[SLOT_W-1:0];

  // Numerator of the tempo division
  assign prod = PROD_W'(Q4_PER_MINUTE_MS) * PROD_W'(intervals);

  tte_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (TAP_SLOTS)
  ) u_stamp_ring (
    .clk   (clk),
    .we    (store),
    .waddr (slot_new),
    .wdata (in_data.stamp_ms),
    .re    (accept),
    .raddr (oldest_slot),
    .rdata (oldest_stamp)
  );

  // Intervals telescope: their wrapping sum is newest minus oldest
  assign span = newest_r - oldest_stamp;

  // Sequence the accept and push cycles
  always_comb begin
    state_nxt       = state_r;
    q_wr.push       = 1'b0;
    q_wr.job.kind   = kind_r;
    q_wr.job.held   = held_r;
    q_wr.job.num    = num_r;
    q_wr.job.sum    = (kind_r == JOB_DIV) ? span : '0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_wr.push = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      write_slot_r <= '0;
      tap_total_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (store) begin
        write_slot_r <= slot_next;
        tap_total_r  <= tot_new;
      end
    end
  end

  // Capture the job fields of an accepted tap
  always_ff @(posedge clk) begin
    if (store) begin
      last_stamp_r <= in_data.stamp_ms;
    end
    if (accept) begin
      newest_r <= in_data.stamp_ms;
      num_r    <= prod[NUM_W-1:0];
      if (in_data.hold) begin
        kind_r <= JOB_PASS;
        held_r <= held_field(32'(tap_total_r));
      end else begin
        kind_r <= (tot_new >= TWO_CNT) ? JOB_DIV : JOB_PASS;
        held_r <= held_field(32'(tot_new));
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tte_back.sv
// Divider back end: serial tempo division, range test and output register.
// Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire tte_pkg::job_t                 q_data,
  output      logic                          q_pop,
  input  wire logic [tte_pkg::TEMPO_W-1:0]   tempo_min,
  input  wire logic [tte_pkg::TEMPO_W-1:0]   tempo_max,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      tte_pkg::out_t                 out_data
);

  import tte_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  back_state_t          state_r, state_nxt;
  logic [STAMP_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [STAMP_W-1:0]   div_r, div_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic                 out_free;
  logic                 direct;
  logic [STAMP_W:0]     trial, diff;
  logic                 fits;
  logic                 in_range;
  logic [TEMPO_W-1:0]   tempo_sat;

  assign out_free = !out_valid_r || !out_stall;
  assign direct   = (q_data.kind == JOB_PASS) || (q_data.sum == '0);

  // One restoring division step
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  // Saturate and range-test the quotient
  assign tempo_sat = (quo_r > NUM_W'(TEMPO_SAT)) ? TEMPO_SAT : quo_r[TEMPO_W-1:0];
  assign in_range  = (quo_r >= NUM_W'(tempo_min)) && (quo_r <= NUM_W'(tempo_max));

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_nxt       = div_r;
    held_nxt      = held_r;
    step_nxt      = step_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && (!direct || out_free)) begin
          q_pop = 1'b1;
          if (direct) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.tempo_valid = 1'b0;
            out_data_nxt.tempo_q4  = (q_data.kind == JOB_PASS) ? '0 : TEMPO_SAT;
            out_data_nxt.taps_held = q_data.held;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = q_data.num;
            div_nxt   = q_data.sum;
            held_nxt  = q_data.held;
            step_nxt  = '0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt  = fits ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
        quo_nxt  = {quo_r[NUM_W-2:0], fits};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        // Hold the quotient until the output register frees up
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.tempo_valid = in_range;
          out_data_nxt.tempo_q4    = tempo_sat;
          out_data_nxt.taps_held   = held_r;
          state_nxt                = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_r      <= div_nxt;
    held_r     <= held_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
